[hw/rtl/hashp_pkg.sv]
`timescale 1ns / 1ps

package hashp_pkg;

  localparam int TABLE_SLOTS_DEF = 128;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int KEY_BITS      = 32;
  localparam int OUT_BITS      = 32;
  localparam int SLOT_IN_BITS  = 7;
  localparam int REQ_BITS      = 2;

  // Start-slot reduction for a table size that is not a power of two
  localparam int MOD_CHUNK_BITS = 8;
  localparam int MOD_STEPS      = KEY_BITS / MOD_CHUNK_BITS;

  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_WRITE  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd2;

endpackage

[hw/rtl/hash_table_probe_lookup.sv]
`timescale 1ns / 1ps

// Write: busy stays low. Clear: one slot a cycle through the memory write port. Lookup:
// one memory read per probe, with done raised once the probing ends (a start-slot reduction
// runs first when TABLE_SLOTS is not a power of two); a new beat can start in the cycle
// done is high. Reset runs the clearing pass (busy high). The receiver cannot stall.
module hash_table_probe_lookup #(
  parameter int TABLE_SLOTS = hashp_pkg::TABLE_SLOTS_DEF,
  parameter int VALUE_BITS  = hashp_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [hashp_pkg::REQ_BITS-1:0]       req_type,
  input  logic [hashp_pkg::SLOT_IN_BITS-1:0]   slot_index,
  input  logic [hashp_pkg::KEY_BITS-1:0]       entry_key,
  input  logic [hashp_pkg::OUT_BITS-1:0]       entry_value,
  output logic                                 done,
  output logic                                 found,
  output logic [hashp_pkg::OUT_BITS-1:0]       found_value
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int RW    = IDX_W + 1;
  localparam int MCW   = $clog2(hashp_pkg::MOD_STEPS);
  localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

  localparam logic [RW-1:0]    SLOTS_R   = RW'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [MCW-1:0]   MOD_LAST  = MCW'(hashp_pkg::MOD_STEPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_MOD   = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  // Memories
  logic [hashp_pkg::KEY_BITS-1:0] key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0]          val_mem [TABLE_SLOTS];
  logic [hashp_pkg::KEY_BITS-1:0] rd_key;
  logic [VALUE_BITS-1:0]          rd_val;

  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [hashp_pkg::KEY_BITS-1:0] wr_key;
  logic [VALUE_BITS-1:0]          wr_val;

  logic [1:0]                     state, state_next;
  logic [IDX_W-1:0]               clr_addr, clr_addr_next;
  logic [IDX_W-1:0]               cur_slot, cur_slot_next;
  logic [IDX_W-1:0]               probe_cnt, probe_cnt_next;
  logic [hashp_pkg::KEY_BITS-1:0] search_key, search_key_next;
  logic [IDX_W-1:0]               mod_rem, mod_rem_next;
  logic [hashp_pkg::KEY_BITS-1:0] mod_sr, mod_sr_next;
  logic [MCW-1:0]                 mod_cnt, mod_cnt_next;
  logic                           done_next, found_next;
  logic [hashp_pkg::OUT_BITS-1:0] found_value_next;

  logic                           accept;
  logic                           write_ok;
  logic [IDX_W-1:0]               rem_step;
  logic [IDX_W-1:0]               next_slot;
  logic                           hit, empty;

  // Fold one chunk of key bits, MSB first, into the running remainder
  function automatic logic [IDX_W-1:0] mod_fold(
    input logic [IDX_W-1:0]                     r_in,
    input logic [hashp_pkg::MOD_CHUNK_BITS-1:0] chunk
  );
    logic [RW-1:0]    t;
    logic [IDX_W-1:0] r;
    r = r_in;
    for (int i = hashp_pkg::MOD_CHUNK_BITS - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= SLOTS_R) begin
        t = t - SLOTS_R;
      end
      r = t[IDX_W-1:0];
    end
    return r;
  endfunction

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign write_ok = (32'(slot_index) < 32'(TABLE_SLOTS));
  assign rem_step = mod_fold(mod_rem,
                             mod_sr[hashp_pkg::KEY_BITS-1 -: hashp_pkg::MOD_CHUNK_BITS]);
  assign next_slot = (cur_slot == '0) ? SLOT_LAST : (cur_slot - 1'b1);
  assign hit      = (rd_key == search_key);
  assign empty    = (rd_key == '0);

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    cur_slot_next    = cur_slot;
    probe_cnt_next   = probe_cnt;
    search_key_next  = search_key;
    mod_rem_next     = mod_rem;
    mod_sr_next      = mod_sr;
    mod_cnt_next     = mod_cnt;
    done_next        = 1'b0;
    found_next       = found;
    found_value_next = found_value;
    rd_en            = 1'b0;
    rd_addr          = cur_slot;
    wr_en            = 1'b0;
    wr_addr          = clr_addr;
    wr_key           = '0;
    wr_val           = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            hashp_pkg::REQ_CLEAR: begin
              state_next    = ST_CLEAR;
              clr_addr_next = '0;
            end
            hashp_pkg::REQ_WRITE: begin
              wr_en   = write_ok;
              wr_addr = IDX_W'(slot_index);
              wr_key  = entry_key;
              wr_val  = VALUE_BITS'(entry_value);
            end
            hashp_pkg::REQ_LOOKUP: begin
              search_key_next = entry_key;
              probe_cnt_next  = '0;
              if (IS_POW2) begin
                rd_en         = 1'b1;
                rd_addr       = entry_key[IDX_W-1:0];
                cur_slot_next = entry_key[IDX_W-1:0];
                state_next    = ST_PROBE;
              end else begin
                mod_rem_next = '0;
                mod_sr_next  = entry_key;
                mod_cnt_next = '0;
                state_next   = ST_MOD;
              end
            end
            default: begin
              // unused request code: drop the beat
            end
          endcase
        end
      end
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == SLOT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_MOD: begin
        mod_rem_next = rem_step;
        mod_sr_next  = mod_sr << hashp_pkg::MOD_CHUNK_BITS;
        mod_cnt_next = mod_cnt + 1'b1;
        if (mod_cnt == MOD_LAST) begin
          rd_en         = 1'b1;
          rd_addr       = rem_step;
          cur_slot_next = rem_step;
          state_next    = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          done_next        = 1'b1;
          found_next       = 1'b1;
          found_value_next = hashp_pkg::OUT_BITS'(rd_val);
          state_next       = ST_IDLE;
        end else if (empty || (probe_cnt == SLOT_LAST)) begin
          done_next        = 1'b1;
          found_next       = 1'b0;
          found_value_next = '0;
          state_next       = ST_IDLE;
        end else begin
          // advance one slot down, wrapping at the bottom
          rd_en          = 1'b1;
          rd_addr        = next_slot;
          cur_slot_next  = next_slot;
          probe_cnt_next = probe_cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_slot    <= cur_slot_next;
    probe_cnt   <= probe_cnt_next;
    search_key  <= search_key_next;
    mod_rem     <= mod_rem_next;
    mod_sr      <= mod_sr_next;
    mod_cnt     <= mod_cnt_next;
    found       <= found_next;
    found_value <= found_value_next;
  end

endmodule
